>>> src/fust_pkg.sv
`default_nettype none

package fust_pkg;

  // Width of one symbol code
  localparam int unsigned SYM_W = 5;

  // One queue slot: a symbol that has so far occurred exactly once
  typedef struct packed {
    logic             vld;
    logic [SYM_W-1:0] sym;
  } entry_t;

  // Broadcast from the top level to every cell for the current word
  typedef struct packed {
    logic             step;    // a word is accepted this cycle
    logic             clr;     // drop all history before counting
    logic             sym_ok;  // symbol lies inside the alphabet
    logic             seen;    // symbol occurred before (after any clear)
    logic [SYM_W-1:0] sym;
  } ctrl_t;

endpackage

`default_nettype wire

>>> src/fust_cell.sv
`default_nettype none

module fust_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fust_pkg::ctrl_t ctrl,
  input  wire logic            left_vld,   // left neighbor holds an entry
  input  wire logic            kill_in,    // an entry to the left leaves
  input  wire fust_pkg::entry_t right_in,  // right neighbor's current entry
  output logic                 kill_out,
  output fust_pkg::entry_t     cur,        // this cell's entry after any clear
  output fust_pkg::entry_t     nxt         // this cell's entry after the word
);

  logic                        vld_r;
  logic [fust_pkg::SYM_W-1:0]  sym_r;
  logic                        match;
  logic                        app;

  // Current entry, with a pending clear applied
  always_comb begin
    cur.vld = vld_r & ~ctrl.clr;
    cur.sym = sym_r;
  end

  // A repeated symbol leaves the queue; everything behind it moves up
  assign match    = cur.vld && ctrl.sym_ok && ctrl.seen && (sym_r == ctrl.sym);
  assign kill_out = kill_in | match;

  // A new symbol lands in the first free cell
  assign app = ctrl.sym_ok && !ctrl.seen && !cur.vld && left_vld;

  always_comb begin
    if (kill_out) begin
      nxt = right_in;
    end else if (app) begin
      nxt.vld = 1'b1;
      nxt.sym = ctrl.sym;
    end else begin
      nxt = cur;
    end
  end

  // Hold the entry between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.step) begin
      vld_r <= nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      sym_r <= nxt.sym;
    end
  end

endmodule

`default_nettype wire

>>> src/first_unique_symbol_tracker_unit.sv
`default_nettype none

// First unique symbol tracker. Each input word carries one symbol index
// (in_tdata) and a new-stream flag (in_tuser) that clears all history before
// the symbol is counted. For every accepted word exactly one result word is
// returned: out_tuser says whether some symbol so far occurred exactly once,
// and out_tdata gives the earliest such symbol (zero when none). Symbols at
// or above ALPHABET_SIZE are not counted. The block takes one word per cycle
// and the result appears in the cycle after acceptance; the queue of unique
// symbols is a row of ALPHABET_SIZE cells that compacts in the same cycle,
// so the ripple of the remove signal along that row sets the clock limit.
// A stalled result holds the input off until it is taken.

module first_unique_symbol_tracker_unit #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [4:0] symbol, [7:5] zero
  input  wire logic       in_tuser,    // [0] new_stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [4:0] first_unique, [7:5] zero
  output logic            out_tuser    // [0] found
);

  localparam int unsigned SEEN_N = (ALPHABET_SIZE < 32) ? ALPHABET_SIZE : 32;
  localparam int unsigned IDX_W  = $clog2(SEEN_N);

  fust_pkg::ctrl_t                ctrl;
  fust_pkg::entry_t               cur  [ALPHABET_SIZE];
  fust_pkg::entry_t               nxt  [ALPHABET_SIZE];
  logic [ALPHABET_SIZE:0]         kill;
  logic [SEEN_N-1:0]              seen_r;
  logic [SEEN_N-1:0]              seen_nxt;
  logic [IDX_W-1:0]               idx;
  logic [fust_pkg::SYM_W-1:0]     sym;
  logic                           out_vld_r;
  logic                           found_r;
  logic [fust_pkg::SYM_W-1:0]     first_r;
  logic                           accept;

  // Take a word whenever the result slot is free or being emptied
  assign in_tready = !out_vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign sym = in_tdata[fust_pkg::SYM_W-1:0];
  assign idx = sym[IDX_W-1:0];

  // Broadcast the word to the cells
  always_comb begin
    ctrl.step   = accept;
    ctrl.clr    = in_tuser;
    ctrl.sym    = sym;
    ctrl.sym_ok = (32'(sym) < ALPHABET_SIZE);
    ctrl.seen   = seen_r[idx] && !in_tuser;
  end

  // Track which symbols have occurred at least once
  always_comb begin
    seen_nxt = in_tuser ? '0 : seen_r;
    if (ctrl.sym_ok) begin
      seen_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
    end
  end

  // Row of queue cells, head at cell zero
  assign kill[0] = 1'b0;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    fust_pkg::entry_t right;
    logic             left_vld;

    if (i == ALPHABET_SIZE - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cur[i+1];
    end

    if (i == 0) begin : g_head
      assign left_vld = 1'b1;
    end else begin : g_body
      assign left_vld = cur[i-1].vld;
    end

    fust_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .left_vld (left_vld),
      .kill_in  (kill[i]),
      .right_in (right),
      .kill_out (kill[i+1]),
      .cur      (cur[i]),
      .nxt      (nxt[i])
    );
  end

  // Register the result word from the new queue head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (accept) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r <= nxt[0].vld;
      first_r <= nxt[0].vld ? nxt[0].sym : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = found_r;
  assign out_tdata  = {(8 - fust_pkg::SYM_W)'(0), first_r};

endmodule

`default_nettype wire
